[design/pldt_pkg.sv]
// shared types and constants for the pin edge timestamp and latency block
`default_nettype none
package pldt_pkg;

   // channel layout: start pins in the low bits, end pins above
   localparam int START_CHANNELS = 2;
   localparam int END_CHANNELS   = 2;
   localparam int ALL_CHANNELS   = START_CHANNELS + END_CHANNELS;
   localparam int CH_W           = 2;
   localparam int STAMP_W        = 48;
   localparam int COUNT_W        = 32;
   localparam int CSR_IDX_W      = 2;
   localparam int REQ_DATA_W     = 8;
   localparam int RSP_DATA_W     = 136;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_START_TRIG = 2'd0,
      REG_END_TRIG   = 2'd1,
      REG_MON_START  = 2'd2,
      REG_MON_END    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic start_trig;
      logic end_trig;
      logic mon_start;
      logic mon_end;
   } cfg_type;

   // per-lane edge record
   typedef struct packed {
      logic                    changed;
      logic                    level;
      logic                    trig;
      logic [ALL_CHANNELS-1:0] snapshot;
   } lane_evt_type;

   // captured frame handed to the emitter
   typedef struct packed {
      logic [STAMP_W-1:0]                   stamp;
      lane_evt_type [ALL_CHANNELS-1:0]      evt;
      logic [ALL_CHANNELS-1:0]              done;
      logic                                 complete;
      logic [STAMP_W-1:0]                   elapsed;
   } frame_type;

endpackage
`default_nettype wire

[design/pin_edge_timestamp_latency.sv]
// top level: pin edge timestamping with start-to-end latency measurement
//
// req channel: one transaction per sample frame, req_tdata[3:0] holds the pin
// levels (bits 0-1 start pins, bits 2-3 end pins). A 48-bit frame counter
// advances by one per accepted frame and stamps its events.
// rsp channel: one transaction per pin that changed, start pins first, in
// ascending channel order; rsp_tlast marks the final event of a frame.
// csr port: csr_we writes csr_wdata into register csr_index in the same edge
// (0 start trigger level, 1 end trigger level, 2 monitored start channel,
// 3 monitored end channel); write only while the block is idle.
// An accepted frame passes the capture register and then the emitter register
// before its first event is valid on the rsp channel.
// The emitter sends one event per cycle while the receiver is ready, one per
// changed pin (1 to 4 per frame); a frame with no change produces nothing and
// is never handed to the emitter.
// A captured frame waits in the capture register while the emitter drains
// the previous one, so req_tready stays high unless both hold a frame and
// the emitter is not sending its last event. When the receiver stalls, the
// current event holds and upstream fills up.
// Reset clears levels, frame counter, arm state and totals, and loads the
// register defaults (start trigger 1, end trigger 0, channels 0).
`default_nettype none
module pin_edge_timestamp_latency (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // pin_levels[3:0], zero padded
   input  wire logic [pldt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // frame_stamp[47:0], pin_channel[49:48], pin_level[50], trigger_match[51],
   // pin_snapshot[55:52], latency_total[103:56], latency_count[135:104]
   output      logic [pldt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // is_start[0]
   output      logic                            rsp_tuser,
   output      logic                            rsp_tlast,
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic                            csr_we,
   input  wire logic [pldt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic                            csr_wdata
);
   import pldt_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      frame_valid;
   frame_type frame;
   logic      frame_take;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_START_TRIG: cfg_in.start_trig = csr_wdata;
            REG_END_TRIG:   cfg_in.end_trig   = csr_wdata;
            REG_MON_START:  cfg_in.mon_start  = csr_wdata;
            REG_MON_END:    cfg_in.mon_end    = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_trig <= 1'b1;
         cfg_ff.end_trig   <= 1'b0;
         cfg_ff.mon_start  <= 1'b0;
         cfg_ff.mon_end    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // lane array and frame state
   pldt_capture u_capture (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .levels      (req_tdata[ALL_CHANNELS-1:0]),
      .frame_valid (frame_valid),
      .frame       (frame),
      .frame_take  (frame_take)
   );

   // event serializer and latency totals
   pldt_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (frame_valid),
      .frame       (frame),
      .frame_take  (frame_take),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
`default_nettype wire

[design/pldt_lane.sv]
// one channel lane: edge detect, trigger match, snapshot and monitor hits
`default_nettype none
module pldt_lane #(
   parameter int LANE = 0
) (
   input  wire logic [pldt_pkg::ALL_CHANNELS-1:0] levels,
   input  wire logic [pldt_pkg::ALL_CHANNELS-1:0] prior,
   input  wire pldt_pkg::cfg_type                 cfg,
   output      pldt_pkg::lane_evt_type            evt,
   output      logic                              start_hit,
   output      logic                              end_hit
);
   import pldt_pkg::*;

   localparam bit IS_START  = (LANE < START_CHANNELS);
   localparam int LOCAL_IDX = IS_START ? LANE : LANE - START_CHANNELS;
   localparam logic [ALL_CHANNELS-1:0] LOW_MASK =
      ALL_CHANNELS'((1 << (LANE + 1)) - 1);

   logic trig_lvl;
   logic mon_sel;
   logic hit;

   // side-dependent trigger level and monitored channel
   assign trig_lvl = IS_START ? cfg.start_trig : cfg.end_trig;
   assign mon_sel  = IS_START ? cfg.mon_start : cfg.mon_end;

   // edge record; snapshot has all lanes up to this one already updated
   assign evt.changed  = levels[LANE] ^ prior[LANE];
   assign evt.level    = levels[LANE];
   assign evt.trig     = (levels[LANE] == trig_lvl);
   assign evt.snapshot = (levels & LOW_MASK) | (prior & ~LOW_MASK);

   // triggering edge on the monitored channel of this side
   assign hit       = evt.changed && evt.trig && (mon_sel == 1'(LOCAL_IDX));
   assign start_hit = IS_START && hit;
   assign end_hit   = !IS_START && hit;

endmodule
`default_nettype wire

[design/pldt_capture.sv]
// frame capture: lane array, frame counter, arm state and elapsed time
`default_nettype none
module pldt_capture (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire pldt_pkg::cfg_type                 cfg,
   input  wire logic                              in_valid,
   output      logic                              in_ready,
   input  wire logic [pldt_pkg::ALL_CHANNELS-1:0] levels,
   output      logic                              frame_valid,
   output      pldt_pkg::frame_type               frame,
   input  wire logic                              frame_take
);
   import pldt_pkg::*;

   logic [ALL_CHANNELS-1:0] prior_ff, prior_in;
   logic [STAMP_W-1:0]      counter_ff, counter_in;
   logic [STAMP_W-1:0]      arm_frame_ff, arm_frame_in;
   logic                    armed_ff, armed_in;
   logic                    valid_ff, valid_in;
   frame_type               frame_ff, frame_in;

   lane_evt_type [ALL_CHANNELS-1:0] evt;
   logic [ALL_CHANNELS-1:0]         start_hit;
   logic [ALL_CHANNELS-1:0]         end_hit;
   logic [ALL_CHANNELS-1:0]         changed;
   logic                            accept;
   logic                            arm;
   logic                            complete;

   // one lane per channel
   for (genvar g = 0; g < ALL_CHANNELS; g++) begin : g_lane
      pldt_lane #(.LANE(g)) u_lane (
         .levels    (levels),
         .prior     (prior_ff),
         .cfg       (cfg),
         .evt       (evt[g]),
         .start_hit (start_hit[g]),
         .end_hit   (end_hit[g])
      );
      assign changed[g] = evt[g].changed;
   end

   assign in_ready = !valid_ff || frame_take;
   assign accept   = in_valid && in_ready;

   // arming precedes the end edge within a frame
   assign arm      = |start_hit;
   assign complete = (|end_hit) && (armed_ff || arm);

   // next frame record
   always_comb begin
      frame_in.stamp    = counter_ff;
      frame_in.evt      = evt;
      frame_in.done     = end_hit & {ALL_CHANNELS{complete}};
      frame_in.complete = complete;
      frame_in.elapsed  = arm ? '0 : counter_ff - arm_frame_ff;
   end

   // state update on each accepted frame; the frame flag clears when taken
   always_comb begin
      prior_in     = prior_ff;
      counter_in   = counter_ff;
      arm_frame_in = arm_frame_ff;
      armed_in     = armed_ff;
      valid_in     = valid_ff;
      if (accept) begin
         prior_in   = levels;
         counter_in = counter_ff + STAMP_W'(1);
         if (arm) begin
            arm_frame_in = counter_ff;
         end
         armed_in = complete ? 1'b0 : (arm || armed_ff);
         valid_in = |changed;
      end else if (frame_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_ff     <= '0;
         counter_ff   <= '0;
         arm_frame_ff <= '0;
         armed_ff     <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         prior_ff     <= prior_in;
         counter_ff   <= counter_in;
         arm_frame_ff <= arm_frame_in;
         armed_ff     <= armed_in;
         valid_ff     <= valid_in;
      end
   end

   // payload holds while the emitter is busy
   always_ff @(posedge clock) begin
      if (accept) begin
         frame_ff <= frame_in;
      end
   end

   assign frame_valid = valid_ff;
   assign frame       = frame_ff;

endmodule
`default_nettype wire

[design/pldt_emit.sv]
// merge stage: latency accumulation and one event per cycle out of a frame while the receiver is ready
`default_nettype none
module pldt_emit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                frame_valid,
   input  wire pldt_pkg::frame_type                 frame,
   output      logic                                frame_take,
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [pldt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output      logic                                rsp_tuser,
   output      logic                                rsp_tlast
);
   import pldt_pkg::*;

   logic                            valid_ff, valid_in;
   logic [ALL_CHANNELS-1:0]         pending_ff, pending_in;
   logic [STAMP_W-1:0]              stamp_ff;
   lane_evt_type [ALL_CHANNELS-1:0] evt_ff;
   logic [ALL_CHANNELS-1:0]         done_ff;
   logic [STAMP_W-1:0]              sum_ff, sum_in;
   logic [COUNT_W-1:0]              cnt_ff, cnt_in;
   logic [STAMP_W-1:0]              prev_sum_ff;
   logic [COUNT_W-1:0]              prev_cnt_ff;

   logic [CH_W-1:0]         sel;
   logic [ALL_CHANNELS-1:0] sel_hot;
   logic [ALL_CHANNELS-1:0] upto_mask;
   logic                    last;
   logic                    fire;
   logic                    load;
   logic [STAMP_W:0]        sum_wide;
   logic                    use_new;
   lane_evt_type            cur;
   logic [STAMP_W-1:0]      total;
   logic [COUNT_W-1:0]      count;
   logic [ALL_CHANNELS-1:0] frame_changed;

   // lowest pending channel goes next
   always_comb begin
      sel = '0;
      for (int i = ALL_CHANNELS - 1; i >= 0; i--) begin
         if (pending_ff[i]) begin
            sel = CH_W'(i);
         end
      end
   end

   assign sel_hot   = ALL_CHANNELS'(1) << sel;
   assign upto_mask = (sel_hot << 1) - ALL_CHANNELS'(1);
   assign last      = (pending_ff & ~sel_hot) == '0;
   assign fire      = valid_ff && rsp_tready;
   assign frame_take = !valid_ff || (fire && last);
   assign load      = frame_take && frame_valid;

   for (genvar g = 0; g < ALL_CHANNELS; g++) begin : g_chg
      assign frame_changed[g] = frame.evt[g].changed;
   end

   // saturating latency update when the frame enters
   assign sum_wide = {1'b0, sum_ff} + {1'b0, frame.elapsed};

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (load && frame.complete) begin
         sum_in = sum_wide[STAMP_W] ? '1 : sum_wide[STAMP_W-1:0];
         cnt_in = (cnt_ff == '1) ? cnt_ff : cnt_ff + COUNT_W'(1);
      end
   end

   // pending set and output valid
   always_comb begin
      valid_in   = valid_ff;
      pending_in = pending_ff;
      if (fire) begin
         pending_in = pending_ff & ~sel_hot;
      end
      if (frame_take) begin
         valid_in   = frame_valid;
         pending_in = frame_changed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         pending_ff <= '0;
         sum_ff     <= '0;
         cnt_ff     <= '0;
      end else begin
         valid_ff   <= valid_in;
         pending_ff <= pending_in;
         sum_ff     <= sum_in;
         cnt_ff     <= cnt_in;
      end
   end

   // frame payload and totals from before this frame
   always_ff @(posedge clock) begin
      if (load) begin
         stamp_ff    <= frame.stamp;
         evt_ff      <= frame.evt;
         done_ff     <= frame.done;
         prev_sum_ff <= sum_ff;
         prev_cnt_ff <= cnt_ff;
      end
   end

   // events from the completing end edge onward see the new totals
   assign use_new = |(done_ff & upto_mask);
   assign cur     = evt_ff[sel];
   assign total   = use_new ? sum_ff : prev_sum_ff;
   assign count   = use_new ? cnt_ff : prev_cnt_ff;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {count, total, cur.snapshot, cur.trig, cur.level, sel, stamp_ff};
   assign rsp_tuser  = (32'(sel) < START_CHANNELS);
   assign rsp_tlast  = last;

   a_pending_nonempty: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> pending_ff != '0)
      else $error("output valid with no pending event");

   a_one_completion: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> $onehot0(done_ff))
      else $error("more than one completion in a frame");

   a_sum_monotone: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (sum_ff >= $past(sum_ff) && cnt_ff >= $past(cnt_ff)))
      else $error("latency totals decreased");

   a_drain_order: assert property (@(posedge clock) disable iff (reset)
      (fire && !last) |=> (valid_ff && pending_ff == $past(pending_ff & ~sel_hot)))
      else $error("pending event lost or repeated");

endmodule
`default_nettype wire

[test/tb_pin_edge_timestamp_latency.sv]
// testbench for the pin edge timestamp and latency block
`timescale 1ns / 1ps
module tb_pin_edge_timestamp_latency;
   import pldt_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 80;
   localparam int DIRECTED_ROWS = 16;

   // one expected edge event, fields in output order
   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [CH_W-1:0]    chan;
      logic               lvl;
      logic               start;
      logic               trig;
      logic [3:0]         snap;
      logic [STAMP_W-1:0] total;
      logic [COUNT_W-1:0] count;
      logic               last;
   } pin_evt_type;

   // directed frame: pin levels, plus the event when it is obvious
   typedef struct {
      logic [3:0]  pins;
      logic        typed;
      pin_evt_type evt;
   } frame_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic                  csr_wdata  = 1'b0;

   // mirror of the block's settings and state
   cfg_type            cfg_mirror;
   logic [3:0]         lv_prev;
   logic [STAMP_W-1:0] frame_no;
   logic [STAMP_W-1:0] arm_at;
   logic               is_armed;
   logic [STAMP_W-1:0] lat_sum;
   logic [COUNT_W-1:0] lat_cnt;

   pin_evt_type   frame_evts [ALL_CHANNELS];
   int            frame_evt_n;
   pin_evt_type   pending_edges [$];
   pin_evt_type   head_evt;
   frame_row_type directed_frames [DIRECTED_ROWS];
   logic [3:0]    last_pins;

   int   send_idle_pct = 0;
   int   stall_pct     = 0;
   logic hold_req      = 1'b0;
   int   hold_left     = 0;
   int   err_count     = 0;
   int   frames_sent   = 0;
   int   events_checked = 0;
   int   cycle_count   = 0;

   pin_edge_timestamp_latency u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // clock, 4 ns period
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d events outstanding", cycle_count,
                pending_edges.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off counted here
   always @(posedge clock) begin
      if (hold_req) begin
         hold_req   <= 1'b0;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         err_count++;
      end
   endtask

   // result checker, sampled mid-cycle so the handshake is settled
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_edges.size() == 0) begin
            $error("unexpected event transaction: tdata %0h", rsp_tdata);
            err_count++;
         end else begin
            head_evt = pending_edges.pop_front();
            check_field("frame_stamp",   64'(head_evt.stamp), 64'(rsp_tdata[47:0]));
            check_field("pin_channel",   64'(head_evt.chan),  64'(rsp_tdata[49:48]));
            check_field("pin_level",     64'(head_evt.lvl),   64'(rsp_tdata[50]));
            check_field("trigger_match", 64'(head_evt.trig),  64'(rsp_tdata[51]));
            check_field("pin_snapshot",  64'(head_evt.snap),  64'(rsp_tdata[55:52]));
            check_field("latency_total", 64'(head_evt.total), 64'(rsp_tdata[103:56]));
            check_field("latency_count", 64'(head_evt.count), 64'(rsp_tdata[135:104]));
            check_field("is_start",      64'(head_evt.start), 64'(rsp_tuser));
            check_field("last_of_frame", 64'(head_evt.last),  64'(rsp_tlast));
         end
         events_checked++;
      end
   end

   // edge events of one frame, updating the arm state and latency totals
   task automatic predict_frame(input logic [3:0] pins);
      logic [3:0]         snap;
      logic [STAMP_W-1:0] elapsed;
      logic [STAMP_W:0]   sum;
      logic               start_side;
      pin_evt_type        e;
      snap = lv_prev;
      frame_evt_n = 0;
      for (int ch = 0; ch < ALL_CHANNELS; ch++) begin
         if (snap[ch] != pins[ch]) begin
            snap[ch]   = pins[ch];
            start_side = (ch < START_CHANNELS);
            e.trig = (pins[ch] == (start_side ? cfg_mirror.start_trig : cfg_mirror.end_trig));
            // start edge arms, or restarts an armed measurement
            if (start_side && e.trig && ch == cfg_mirror.mon_start) begin
               arm_at   = frame_no;
               is_armed = 1'b1;
            end
            // end edge closes it, both totals saturate
            if (!start_side && e.trig && is_armed
                && (ch - START_CHANNELS) == cfg_mirror.mon_end) begin
               elapsed  = frame_no - arm_at;
               sum      = {1'b0, lat_sum} + elapsed;
               lat_sum  = sum[STAMP_W] ? '1 : sum[STAMP_W-1:0];
               if (lat_cnt != '1)
                  lat_cnt = lat_cnt + 1;
               is_armed = 1'b0;
            end
            e.stamp = frame_no;
            e.chan  = CH_W'(ch);
            e.lvl   = pins[ch];
            e.start = start_side;
            e.snap  = snap;
            e.total = lat_sum;
            e.count = lat_cnt;
            e.last  = 1'b0;
            frame_evts[frame_evt_n] = e;
            frame_evt_n++;
         end
      end
      if (frame_evt_n > 0)
         frame_evts[frame_evt_n-1].last = 1'b1;
      lv_prev  = snap;
      frame_no = frame_no + 1;
   endtask

   // offer one frame, with random idle cycles before it
   task automatic push_frame(input logic [3:0] pins, input logic typed,
                             input pin_evt_type typed_evt);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {4'b0000, pins};
      req_tvalid <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end
      predict_frame(pins);
      if (typed)
         pending_edges.push_back(typed_evt);
      else
         for (int i = 0; i < frame_evt_n; i++)
            pending_edges.push_back(frame_evts[i]);
      last_pins = pins;
      frames_sent++;
   endtask

   task automatic send(input logic [3:0] pins);
      push_frame(pins, 1'b0, '0);
   endtask

   // stop offering and wait for every outstanding event
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_edges.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all four registers, only while the block is idle
   task automatic load_settings(input cfg_type c);
      csr_we    <= 1'b1;
      csr_index <= REG_START_TRIG;
      csr_wdata <= c.start_trig;
      @(posedge clock);
      csr_index <= REG_END_TRIG;
      csr_wdata <= c.end_trig;
      @(posedge clock);
      csr_index <= REG_MON_START;
      csr_wdata <= c.mon_start;
      @(posedge clock);
      csr_index <= REG_MON_END;
      csr_wdata <= c.mon_end;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_mirror = c;
   endtask

   // random phase: mostly start/end measurement sequences, some noise
   task automatic run_random(input cfg_type c, input int idle_pct, input int stall,
                             input int n_frames, input logic pressure);
      logic [3:0] cur;
      int         target;
      int         first;
      int         kind;
      int         s_pin;
      int         e_pin;
      logic       held;
      logic       paused;
      load_settings(c);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      first  = frames_sent;
      target = frames_sent + n_frames;
      held   = 1'b0;
      paused = 1'b0;
      s_pin  = c.mon_start;
      e_pin  = START_CHANNELS + c.mon_end;
      while (frames_sent < target) begin
         // long receiver hold-off while frames keep coming
         if (pressure && !held && frames_sent >= first + 10) begin
            hold_req <= 1'b1;
            held = 1'b1;
         end
         // sender pause until everything has come back
         if (pressure && !paused && frames_sent >= target - 20) begin
            drain_results();
            paused = 1'b1;
         end
         cur  = last_pins;
         kind = $urandom_range(99);
         if (kind < 45) begin
            cur = 4'($urandom_range(15));
            cur[s_pin] = !c.start_trig;
            cur[e_pin] = !c.end_trig;
            send(cur);
            cur[s_pin] = c.start_trig;
            send(cur);
            repeat ($urandom_range(3)) send(cur);
            cur[e_pin] = c.end_trig;
            send(cur);
         end else if (kind < 70) begin
            cur[$urandom_range(ALL_CHANNELS-1)] ^= 1'b1;
            send(cur);
         end else if (kind < 85) begin
            send(4'($urandom_range(15)));
         end else begin
            send(cur);
         end
      end
      drain_results();
   endtask

   initial begin
      // typed rows follow from the reset settings
      directed_frames = '{
         '{4'b0000, 1'b0, '0},
         '{4'b0001, 1'b1, '{48'd1, 2'd0, 1'b1, 1'b1, 1'b1, 4'b0001, 48'd0, 32'd0, 1'b1}},
         '{4'b0101, 1'b1, '{48'd2, 2'd2, 1'b1, 1'b0, 1'b0, 4'b0101, 48'd0, 32'd0, 1'b1}},
         '{4'b0001, 1'b1, '{48'd3, 2'd2, 1'b0, 1'b0, 1'b1, 4'b0001, 48'd2, 32'd1, 1'b1}},
         '{4'b1111, 1'b0, '0},
         '{4'b0000, 1'b0, '0},
         '{4'b1111, 1'b0, '0},
         '{4'b1111, 1'b0, '0},
         '{4'b0000, 1'b0, '0},
         '{4'b1010, 1'b0, '0},
         '{4'b0101, 1'b0, '0},
         '{4'b1001, 1'b0, '0},
         '{4'b0110, 1'b0, '0},
         '{4'b0011, 1'b0, '0},
         '{4'b1100, 1'b0, '0},
         '{4'b1000, 1'b0, '0}
      };
      lv_prev   = '0;
      frame_no  = '0;
      arm_at    = '0;
      is_armed  = 1'b0;
      lat_sum   = '0;
      lat_cnt   = '0;
      last_pins = '0;
      cfg_mirror = '{1'b1, 1'b0, 1'b0, 1'b0};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed frames at the reset settings, no idling
      load_settings('{1'b1, 1'b0, 1'b0, 1'b0});
      for (int r = 0; r < DIRECTED_ROWS; r++)
         push_frame(directed_frames[r].pins, directed_frames[r].typed,
                    directed_frames[r].evt);
      drain_results();

      // random phases, settings swept including all-zero and all-one
      run_random('{1'b0, 1'b1, 1'b1, 1'b1},  0,  0, 60, 1'b0);
      run_random('{1'b1, 1'b1, 1'b0, 1'b1}, 77,  0, 60, 1'b0);
      run_random('{1'b0, 1'b0, 1'b1, 1'b0},  0, 77, 60, 1'b0);
      run_random('{1'b1, 1'b1, 1'b1, 1'b1}, 23, 23, 60, 1'b0);
      run_random('{1'b0, 1'b0, 1'b0, 1'b0},  0,  0, 60, 1'b1);

      $display("sent %0d frames over six register settings, checked %0d edge events",
               frames_sent, events_checked);
      $display("phases: no idling, sender gaps, receiver stalls, both, long receiver hold");
      if (err_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
